FILE: src/rgbls_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED chain serializer package
// Shared constants, types and state encodings for the frame serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbls_pkg;

  // Capacity of the brightness store, in chips.
  localparam int MAX_CHIPS    = 32;
  localparam int NUM_CHANNELS = 3;
  localparam int LEVEL_W      = 8;
  localparam int CHIP_W       = 6;
  localparam int CHAN_W       = 2;
  localparam int PAYLOAD_W    = NUM_CHANNELS * LEVEL_W;
  localparam int ADDR_W       = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;

  // Operation codes carried on an input beat.
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPLY,
    ST_SCAN,
    ST_FRAME,
    ST_LATCH
  } state_t;

  // Control from the sequencer to the store and the output register.
  typedef struct packed {
    logic              in_ready;
    logic              slot_ok;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              load_reply;
    logic              load_frame;
    logic              load_latch;
  } ctrl_t;

endpackage

FILE: src/rgbls_store.sv
// ----------------------------------------------------------------------------
// Brightness store
// Three banks (red, green, blue) of one level per chip, with a valid bit per
// entry so that an entry never written reads as zero. One write port and one
// registered read port that returns all three channels of a chip.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbls_store import rgbls_pkg::*; (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [ADDR_W-1:0]                     wr_addr,
  input  logic [CHAN_W-1:0]                     wr_chan,
  input  logic [LEVEL_W-1:0]                    wr_data,
  input  logic                                  rd_en,
  input  logic [ADDR_W-1:0]                     rd_addr,
  output logic [NUM_CHANNELS-1:0][LEVEL_W-1:0]  rd_levels
);

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_bank
    logic [LEVEL_W-1:0]   mem [MAX_CHIPS];
    logic [MAX_CHIPS-1:0] vld;
    logic [LEVEL_W-1:0]   q;
    logic                 qv;
    logic                 bank_wr;

    assign bank_wr = wr_en && (wr_chan == CHAN_W'(g));

    // Storage array: written at one address, read at one address.
    always_ff @(posedge clk) begin
      if (bank_wr) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        q <= mem[rd_addr];
      end
    end

    // Valid bits stand in for clearing the array after reset.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= '0;
        qv  <= 1'b0;
      end else begin
        if (bank_wr) begin
          vld[wr_addr] <= 1'b1;
        end
        if (rd_en) begin
          qv <= vld[rd_addr];
        end
      end
    end

    assign rd_levels[g] = qv ? q : '0;
  end

endmodule

FILE: src/rgbls_seq.sv
// ----------------------------------------------------------------------------
// Serializer sequencer
// Decodes an input beat, range-checks the address and walks the chain one
// chip at a time with a single shared counter and compare during an update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbls_seq import rgbls_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        operation,
  input  logic [CHIP_W-1:0] chip_index,
  input  logic [CHAN_W-1:0] channel_index,
  input  logic [CHIP_W-1:0] eff_chips,
  input  logic              out_free,
  output ctrl_t             ctrl
);

  state_t            state;
  state_t            state_next;
  logic [CHIP_W-1:0] idx;
  logic              more_chips;
  logic              slot_ok;
  op_t               op;

  assign op         = op_t'(operation);
  assign more_chips = (idx < eff_chips);
  assign slot_ok    = (chip_index < eff_chips) && (channel_index < CHAN_W'(NUM_CHANNELS));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op)
            OP_READ:   state_next = ST_REPLY;
            OP_UPDATE: state_next = ST_SCAN;
            OP_WRITE:  state_next = ST_IDLE;
            OP_NONE:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_REPLY: if (out_free) state_next = ST_IDLE;
      ST_SCAN:  state_next = more_chips ? ST_FRAME : ST_LATCH;
      ST_FRAME: if (out_free) state_next = ST_SCAN;
      ST_LATCH: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl            = '0;
    ctrl.slot_ok    = slot_ok;
    ctrl.in_ready   = (state == ST_IDLE);
    ctrl.rd_addr    = (state == ST_IDLE) ? chip_index[ADDR_W-1:0] : idx[ADDR_W-1:0];
    ctrl.wr_en      = (state == ST_IDLE) && in_valid && (op == OP_WRITE) && slot_ok;
    ctrl.rd_en      = ((state == ST_IDLE) && in_valid && (op == OP_READ)) ||
                      ((state == ST_SCAN) && more_chips);
    ctrl.load_reply = (state == ST_REPLY) && out_free;
    ctrl.load_frame = (state == ST_FRAME) && out_free;
    ctrl.load_latch = (state == ST_LATCH) && out_free;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Chip counter: cleared when an update is taken, stepped per frame sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if ((state == ST_IDLE) && in_valid && (op == OP_UPDATE)) begin
      idx <= '0;
    end else if ((state == ST_FRAME) && out_free) begin
      idx <= CHIP_W'(idx + 1'b1);
    end
  end

endmodule

FILE: src/rgb_led_chain_frame_serializer_core.sv
// ----------------------------------------------------------------------------
// RGB LED chain frame serializer
// Keeps three brightness levels per chip and, on an update, sends one colour
// frame per chip in use followed by a latch frame marked last.
//
//   Channel  Signals                                   Direction  Role
//   in       in_valid/in_ready, operation, chip_index,  sink       commands
//            channel_index, level
//   out      out_valid/out_ready, is_frame, read_level, source     replies, frames
//            start_bit, frame_payload, last
//   cfg      cfg_valid/cfg_ready, cfg_data             sink       chips_in_use
//
// A write is stored on acceptance; a read loads its reply once the output is free.
// An update walks a scan and a frame state per chip, then a latch state: the
// store has one read port and a single chip counter and compare walks the chain.
// in_ready is low from an accepted read or update until its last beat is
// loaded into the output register; a stall on out_ready stretches that time.
// Reset is synchronous; the store reads as zero until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_led_chain_frame_serializer_core import rgbls_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  input  logic [CHIP_W-1:0]    chip_index,
  input  logic [CHAN_W-1:0]    channel_index,
  input  logic [LEVEL_W-1:0]   level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 is_frame,
  output logic [LEVEL_W-1:0]   read_level,
  output logic                 start_bit,
  output logic [PAYLOAD_W-1:0] frame_payload,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CHIP_W-1:0]    cfg_data
);

  ctrl_t                               ctrl;
  logic [CHIP_W-1:0]                   chips_in_use;
  logic [CHIP_W-1:0]                   eff_chips;
  logic                                out_free;
  logic [NUM_CHANNELS-1:0][LEVEL_W-1:0] levels;
  logic [CHAN_W-1:0]                   rd_chan;
  logic                                rd_ok;
  logic [LEVEL_W-1:0]                  chan_level;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chips_in_use <= CHIP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      chips_in_use <= cfg_data;
    end
  end

  // A count above the store capacity is clamped to it.
  assign eff_chips = (chips_in_use > CHIP_W'(MAX_CHIPS)) ? CHIP_W'(MAX_CHIPS) : chips_in_use;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = ctrl.in_ready;

  rgbls_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .operation     (operation),
    .chip_index    (chip_index),
    .channel_index (channel_index),
    .eff_chips     (eff_chips),
    .out_free      (out_free),
    .ctrl          (ctrl)
  );

  rgbls_store u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (ctrl.wr_en),
    .wr_addr   (chip_index[ADDR_W-1:0]),
    .wr_chan   (channel_index),
    .wr_data   (level),
    .rd_en     (ctrl.rd_en),
    .rd_addr   (ctrl.rd_addr),
    .rd_levels (levels)
  );

  // Remember which channel a read asked for and whether it was in range.
  always_ff @(posedge clk) begin
    if (in_valid && ctrl.in_ready) begin
      rd_chan <= channel_index;
      rd_ok   <= ctrl.slot_ok;
    end
  end

  always_comb begin
    unique case (rd_chan)
      2'd0:    chan_level = levels[0];
      2'd1:    chan_level = levels[1];
      2'd2:    chan_level = levels[2];
      default: chan_level = '0;
    endcase
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_reply || ctrl.load_frame || ctrl.load_latch) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload of the beat.
  always_ff @(posedge clk) begin
    if (ctrl.load_reply) begin
      is_frame      <= 1'b0;
      read_level    <= rd_ok ? chan_level : '0;
      start_bit     <= 1'b0;
      frame_payload <= '0;
      last          <= 1'b0;
    end else if (ctrl.load_frame) begin
      is_frame      <= 1'b1;
      read_level    <= '0;
      start_bit     <= 1'b1;
      frame_payload <= {levels[0], levels[1], levels[2]};
      last          <= 1'b0;
    end else if (ctrl.load_latch) begin
      is_frame      <= 1'b1;
      read_level    <= '0;
      start_bit     <= 1'b0;
      frame_payload <= '0;
      last          <= 1'b1;
    end
  end

  // The latch beat is always an empty frame.
  a_latch_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> is_frame && !start_bit && (frame_payload == '0))
    else $error("latch beat carries a start bit or payload");

  // A read reply never looks like a frame.
  a_reply_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_frame |-> !last && !start_bit && (frame_payload == '0))
    else $error("read reply carries frame fields");

  // No new command is taken while colour frames of an update are going out.
  a_busy_in_update: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_frame && !last |-> !in_ready)
    else $error("input accepted in the middle of an update");

endmodule
